// ===== rtl/mcbm_pkg.sv =====
// Shared types and constants for the multicart bank mapper.
// Holds bus operation codes, result target codes and the decode bundle.
// No dependencies.
package mcbm_pkg;

    localparam int PRG_ADDR_BITS_DEF = 20;
    localparam int CHR_ADDR_BITS_DEF = 19;
    localparam int WRAM_DEPTH_DEF    = 8192;

    localparam int MADDR_W = 20;
    localparam int DATA_W  = 8;
    localparam int NIB_W   = 4;

    typedef enum logic [1:0] {
        OP_CPU_READ  = 2'd0,
        OP_CPU_WRITE = 2'd1,
        OP_PPU_READ  = 2'd2,
        OP_IDLE      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_DATA = 3'd1,
        TGT_PRG  = 3'd2,
        TGT_CHR  = 3'd3,
        TGT_NT   = 3'd4
    } target_t;

    // Decode of one request against the current banking state
    typedef struct packed {
        target_t              target;
        logic [MADDR_W-1:0]   mapped_address;
        logic [NIB_W-1:0]     nibble;
        logic                 wram_read;
        logic                 wram_write;
    } decode_t;

endpackage

// ===== rtl/mcbm_wram.sv =====
// Work RAM for the multicart bank mapper: one port, registered read data.
// Depends on nothing but its parameter.
module mcbm_wram #(
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);
    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mcbm_bank_regs.sv =====
// Banking state and address decode for the multicart bank mapper.
// Depends on mcbm_pkg for op codes, targets and the decode bundle.
module mcbm_bank_regs #(
    parameter int PRG_ADDR_BITS = 20,
    parameter int CHR_ADDR_BITS = 19
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_accept,
    input  logic [1:0]        operation,
    input  logic [15:0]       bus_address,
    input  logic [7:0]        write_data,
    output mcbm_pkg::decode_t decode
);
    import mcbm_pkg::*;

    logic [NIB_W-1:0] nibble_reg [4];
    logic             mirror_h_reg;
    logic             prg_mode_16k_reg;
    logic             prg_half_reg;
    logic [4:0]       prg_bank_reg;
    logic [5:0]       chr_bank_reg;

    op_t         op;
    logic        is_nibble;
    logic        is_wram;
    logic        is_prg;
    logic [13:0] ppu_addr;
    logic [19:0] prg_full;
    logic [18:0] chr_full;
    logic [10:0] nt_addr;

    assign op        = op_t'(operation);
    assign is_nibble = (bus_address[15:12] == 4'h5);
    assign is_wram   = (bus_address[15:13] == 3'b011);
    assign is_prg    = bus_address[15];
    assign ppu_addr  = bus_address[13:0];

    // 16K mode shows the same bank at both halves of the window
    assign prg_full = prg_mode_16k_reg
                    ? {prg_bank_reg, prg_half_reg, bus_address[13:0]}
                    : {prg_bank_reg, bus_address[14:0]};
    assign chr_full = {chr_bank_reg, ppu_addr[12:0]};
    assign nt_addr  = mirror_h_reg ? {ppu_addr[11], ppu_addr[9:0]} : ppu_addr[10:0];

    always_comb
    begin
        decode.target         = TGT_NONE;
        decode.mapped_address = '0;
        decode.nibble         = nibble_reg[bus_address[1:0]];
        decode.wram_read      = 1'b0;
        decode.wram_write     = 1'b0;
        unique case (op)
            OP_CPU_READ:
            begin
                if (is_nibble)
                begin
                    decode.target = TGT_DATA;
                end
                else if (is_wram)
                begin
                    decode.target    = TGT_DATA;
                    decode.wram_read = 1'b1;
                end
                else if (is_prg)
                begin
                    decode.target         = TGT_PRG;
                    decode.mapped_address = MADDR_W'(prg_full[PRG_ADDR_BITS-1:0]);
                end
            end
            OP_CPU_WRITE:
            begin
                decode.wram_write = is_wram;
            end
            OP_PPU_READ:
            begin
                if (!ppu_addr[13])
                begin
                    decode.target         = TGT_CHR;
                    decode.mapped_address = MADDR_W'(chr_full[CHR_ADDR_BITS-1:0]);
                end
                else if (ppu_addr[13:8] != 6'h3F)
                begin
                    decode.target         = TGT_NT;
                    decode.mapped_address = MADDR_W'(nt_addr);
                end
            end
            default:
            begin
                decode.target = TGT_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                nibble_reg[i] <= '0;
            end
            mirror_h_reg     <= 1'b0;
            prg_mode_16k_reg <= 1'b0;
            prg_half_reg     <= 1'b0;
            prg_bank_reg     <= '0;
            chr_bank_reg     <= '0;
        end
        else if (req_accept && (op == OP_CPU_WRITE))
        begin
            if (is_nibble)
            begin
                nibble_reg[bus_address[1:0]] <= write_data[NIB_W-1:0];
            end
            else if (is_prg)
            begin
                mirror_h_reg     <= bus_address[13];
                prg_mode_16k_reg <= bus_address[12];
                prg_half_reg     <= bus_address[6];
                prg_bank_reg     <= bus_address[11:7];
                chr_bank_reg     <= bus_address[5:0];
            end
        end
    end

endmodule

// ===== rtl/multicart_bank_mapper.sv =====
// Top level of the multicart bank mapper: request pipeline and result register.
// Depends on mcbm_pkg, mcbm_bank_regs and mcbm_wram.

// One bus request (CPU read, CPU write or PPU read) enters per cycle while
// in_ready is high and yields exactly one result, in order. The first
// stage decodes the request against the banking state and starts the work RAM
// read; the second stage is the result register, so in_ready stays high while a
// finished result waits, as long as the decode stage is empty. Banking, nibble
// and work RAM writes take effect at the edge the write request is accepted, so
// the very next request already sees them. Sustained rate: one request per cycle
// while the result register drains, set by the single work RAM port, which
// serves one read or one write per request. The work RAM has no reset; reading
// a byte never written returns whatever the array holds.
module multicart_bank_mapper #(
    parameter int PRG_ADDR_BITS = mcbm_pkg::PRG_ADDR_BITS_DEF,
    parameter int CHR_ADDR_BITS = mcbm_pkg::CHR_ADDR_BITS_DEF,
    parameter int WRAM_DEPTH    = mcbm_pkg::WRAM_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  target,
    output logic [19:0] mapped_address,
    output logic [7:0]  read_data
);
    import mcbm_pkg::*;

    localparam int WRAM_AW = $clog2(WRAM_DEPTH);

    decode_t            decode;
    logic               in_accept;
    logic               s1_advance;
    logic [DATA_W-1:0]  wram_rdata;

    // decode stage
    logic               s1_valid_reg;
    target_t            s1_target_reg;
    logic [MADDR_W-1:0] s1_maddr_reg;
    logic [NIB_W-1:0]   s1_nibble_reg;
    logic               s1_wram_reg;

    // result stage
    logic               out_valid_reg;
    target_t            out_target_reg;
    logic [MADDR_W-1:0] out_maddr_reg;
    logic [DATA_W-1:0]  out_data_reg;
    logic [DATA_W-1:0]  out_data_next;

    // Advance the decode stage whenever the result register is empty or drained
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    mcbm_bank_regs #(
        .PRG_ADDR_BITS (PRG_ADDR_BITS),
        .CHR_ADDR_BITS (CHR_ADDR_BITS)
    ) u_bank_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_accept  (in_accept),
        .operation   (operation),
        .bus_address (bus_address),
        .write_data  (write_data),
        .decode      (decode)
    );

    // Read data lands with the request in the decode stage and holds while it stalls
    mcbm_wram #(
        .DEPTH (WRAM_DEPTH)
    ) u_wram (
        .clk   (clk),
        .we    (in_accept && decode.wram_write),
        .re    (in_accept && decode.wram_read),
        .addr  (bus_address[WRAM_AW-1:0]),
        .wdata (write_data),
        .rdata (wram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_target_reg <= decode.target;
            s1_maddr_reg  <= decode.mapped_address;
            s1_nibble_reg <= decode.nibble;
            s1_wram_reg   <= decode.wram_read;
        end
    end

    // Pick work RAM byte or nibble register; zero for everything but data reads
    always_comb
    begin
        if (s1_target_reg != TGT_DATA)
        begin
            out_data_next = '0;
        end
        else if (s1_wram_reg)
        begin
            out_data_next = wram_rdata;
        end
        else
        begin
            out_data_next = DATA_W'(s1_nibble_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_target_reg <= s1_target_reg;
            out_maddr_reg  <= s1_maddr_reg;
            out_data_reg   <= out_data_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign target         = out_target_reg;
    assign mapped_address = out_maddr_reg;
    assign read_data      = out_data_reg;

    // Stall only when both stages are occupied
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low without a full pipeline");

    // A CPU write produces an unmapped result
    a_write_none: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (operation == OP_CPU_WRITE)) |=>
            (s1_valid_reg && (s1_target_reg == TGT_NONE)))
        else $error("CPU write decoded to a mapped target");

    // Data only travels with data results
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_target_reg != TGT_DATA)) |-> (out_data_reg == '0))
        else $error("read_data nonzero on a non-data result");

    // Addresses only travel with translated results
    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ((out_target_reg == TGT_NONE) || (out_target_reg == TGT_DATA)))
            |-> (out_maddr_reg == '0))
        else $error("mapped_address nonzero on an untranslated result");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for multicart_bank_mapper: directed table plus random bus requests.
// Holds its own mapper shadow state and checks every result in order.
// Depends on rtl/mcbm_pkg.sv and rtl/multicart_bank_mapper.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcbm_pkg::*;

    localparam int PRG_BITS       = PRG_ADDR_BITS_DEF;
    localparam int CHR_BITS       = CHR_ADDR_BITS_DEF;
    localparam int RANDOM_ITEMS   = 1900;
    localparam int HOLDOFF_AT     = 600;      // request count that triggers the long output stall
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 16;       // two-stage pipe, plenty of margin
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DIRECTED_ROWS  = 25;

    // One result as the block reports it
    typedef struct packed {
        target_t          tgt;
        logic [19:0]      maddr;
        logic [7:0]       rdata;
    } access_result_t;

    // One row of the directed table; when typed is set the row carries its own answer
    typedef struct packed {
        op_t              op;
        logic [15:0]      addr;
        logic [7:0]       data;
        bit               typed;
        access_result_t   want;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [15:0] bus_address;
    logic [7:0]  write_data;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  target;
    logic [19:0] mapped_address;
    logic [7:0]  read_data;

    // Shadow of the mapper state, advanced once per accepted request
    logic [7:0]  wram_shadow [0:8191];
    bit          wram_written [0:8191];
    logic [12:0] wram_used [$];
    logic [3:0]  nibble_shadow [0:3];
    logic        mirror_h;
    logic        mode_16k;
    logic        half_sel;
    logic [4:0]  prg_bank_q;
    logic [5:0]  chr_bank_q;

    access_result_t expected_results [$];
    int requests_accepted;
    int banking_writes;
    int errors;
    int cycle_count;
    int results_by_target [0:4];

    // Directed requests: reset values, field extremes, every operation and
    // the corner cases (unmapped low CPU space, palette hole, PPU mirror of
    // nametables, ignored PPU high bits, the unused operation code)
    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{OP_CPU_READ,  16'h5000, 8'h00, 1'b1, '{TGT_DATA, 20'h00000, 8'h00}},
        '{OP_CPU_READ,  16'h8000, 8'hFF, 1'b1, '{TGT_PRG,  20'h00000, 8'h00}},
        '{OP_CPU_READ,  16'h0000, 8'h00, 1'b1, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_CPU_READ,  16'h4FFF, 8'h00, 1'b1, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_PPU_READ,  16'h0000, 8'h00, 1'b1, '{TGT_CHR,  20'h00000, 8'h00}},
        '{OP_PPU_READ,  16'h2000, 8'h00, 1'b1, '{TGT_NT,   20'h00000, 8'h00}},
        '{OP_PPU_READ,  16'h3F00, 8'h00, 1'b1, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_IDLE,      16'hFFFF, 8'hFF, 1'b1, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_CPU_WRITE, 16'h5003, 8'hFF, 1'b1, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_CPU_READ,  16'h5003, 8'h00, 1'b1, '{TGT_DATA, 20'h00000, 8'h0F}},
        '{OP_CPU_WRITE, 16'h7FFF, 8'hA5, 1'b1, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_CPU_READ,  16'h7FFF, 8'h00, 1'b1, '{TGT_DATA, 20'h00000, 8'hA5}},
        '{OP_CPU_WRITE, 16'h6000, 8'h00, 1'b1, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_CPU_READ,  16'h6000, 8'hFF, 1'b1, '{TGT_DATA, 20'h00000, 8'h00}},
        '{OP_CPU_WRITE, 16'hFFFF, 8'h00, 1'b1, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_CPU_READ,  16'hFFFF, 8'h00, 1'b1, '{TGT_PRG,  20'hFFFFF, 8'h00}},
        '{OP_CPU_READ,  16'h8000, 8'h00, 1'b1, '{TGT_PRG,  20'hFC000, 8'h00}},
        '{OP_PPU_READ,  16'h1FFF, 8'h00, 1'b1, '{TGT_CHR,  20'h7FFFF, 8'h00}},
        '{OP_PPU_READ,  16'h2FFF, 8'h00, 1'b0, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_PPU_READ,  16'h3EFF, 8'h00, 1'b0, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_PPU_READ,  16'hFFFF, 8'h00, 1'b1, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_PPU_READ,  16'hC000, 8'h00, 1'b0, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_CPU_WRITE, 16'h8000, 8'hFF, 1'b1, '{TGT_NONE, 20'h00000, 8'h00}},
        '{OP_CPU_READ,  16'hC123, 8'h00, 1'b1, '{TGT_PRG,  20'h04123, 8'h00}},
        '{OP_CPU_READ,  16'h5001, 8'h00, 1'b0, '{TGT_NONE, 20'h00000, 8'h00}}
    };

    multicart_bank_mapper u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .bus_address    (bus_address),
        .write_data     (write_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .target         (target),
        .mapped_address (mapped_address),
        .read_data      (read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: end the run if the mapper stops making progress
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL multicart_bank_mapper");
            $finish;
        end
    end

    // Mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the shadow mapper by one request and return the result it owes
    function automatic access_result_t map_access(op_t op, logic [15:0] addr, logic [7:0] data);
        access_result_t res;
        logic [3:0]     page;
        logic [13:0]    ppu_addr;
        logic [31:0]    wide;
        res.tgt   = TGT_NONE;
        res.maddr = '0;
        res.rdata = '0;
        page      = addr[15:12];
        ppu_addr  = addr[13:0];
        case (op)
            OP_CPU_READ:
            begin
                if (page == 4'h5)
                begin
                    res.tgt   = TGT_DATA;
                    res.rdata = {4'h0, nibble_shadow[addr[1:0]]};
                end
                else if (page == 4'h6 || page == 4'h7)
                begin
                    res.tgt   = TGT_DATA;
                    res.rdata = wram_shadow[addr[12:0]];
                end
                else if (page[3])
                begin
                    // 16K mode mirrors one bank at 0x8000 and 0xC000
                    if (mode_16k)
                        wide = {12'h0, prg_bank_q, half_sel, addr[13:0]};
                    else
                        wide = {12'h0, prg_bank_q, addr[14:0]};
                    res.tgt   = TGT_PRG;
                    res.maddr = 20'(wide & ((32'd1 << PRG_BITS) - 1));
                end
            end
            OP_CPU_WRITE:
            begin
                if (page == 4'h5)
                    nibble_shadow[addr[1:0]] = data[3:0];
                else if (page == 4'h6 || page == 4'h7)
                begin
                    wram_shadow[addr[12:0]] = data;
                    if (!wram_written[addr[12:0]])
                    begin
                        wram_written[addr[12:0]] = 1'b1;
                        wram_used.push_back(addr[12:0]);
                    end
                end
                else if (page[3])
                begin
                    // Banking state comes from the address lines, not the data
                    mirror_h   = addr[13];
                    mode_16k   = addr[12];
                    half_sel   = addr[6];
                    prg_bank_q = addr[11:7];
                    chr_bank_q = addr[5:0];
                    banking_writes++;
                end
            end
            OP_PPU_READ:
            begin
                if (ppu_addr < 14'h2000)
                begin
                    wide      = {13'h0, chr_bank_q, ppu_addr[12:0]};
                    res.tgt   = TGT_CHR;
                    res.maddr = 20'(wide & ((32'd1 << CHR_BITS) - 1));
                end
                else if (ppu_addr < 14'h3F00)
                begin
                    // 0x3000-0x3EFF falls through here as a nametable mirror
                    res.tgt = TGT_NT;
                    if (mirror_h)
                        res.maddr = {9'h0, ppu_addr[11], ppu_addr[9:0]};
                    else
                        res.maddr = {9'h0, ppu_addr[10:0]};
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Draw one random request; work RAM reads only hit bytes already written
    task automatic pick_random_access(output op_t op, output logic [15:0] addr,
                                      output logic [7:0] data);
        int r;
        int region;
        r      = $urandom_range(0, 99);
        region = $urandom_range(0, 99);
        data   = 8'($urandom);
        addr   = 16'($urandom);
        if (r < 5)
            op = OP_IDLE;
        else if (r < 40)
            op = OP_CPU_READ;
        else if (r < 72)
            op = OP_CPU_WRITE;
        else
            op = OP_PPU_READ;

        if (op == OP_PPU_READ)
        begin
            // pull some requests into the palette hole, high bits stay random
            if (region < 10)
                addr[13:8] = 6'h3F;
        end
        else if (op != OP_IDLE)
        begin
            if (region < 10)
                addr = 16'($urandom_range(0, 16'h4FFF));
            else if (region < 25)
                addr[15:12] = 4'h5;
            else if (region < 55)
            begin
                if (op == OP_CPU_READ && wram_used.size() == 0)
                    addr[15:12] = 4'h5;
                else if (op == OP_CPU_READ)
                    addr = {3'b011, wram_used[$urandom_range(0, wram_used.size() - 1)]};
                else
                    addr[15:13] = 3'b011;
            end
            else
                addr[15] = 1'b1;
        end
    endtask

    // Offer one request, hold it until accepted, then queue its expected result
    task automatic issue_request(input op_t op, input logic [15:0] addr, input logic [7:0] data,
                                 input bit typed, input access_result_t typed_result);
        int             gap;
        access_result_t predicted;
        // keep offering back to back around the output hold-off and in one late stretch
        if ((requests_accepted >= HOLDOFF_AT && requests_accepted < HOLDOFF_AT + 250) ||
            (requests_accepted >= 1300 && requests_accepted < 1450))
            gap = 0;
        else
            gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        bus_address <= addr;
        write_data  <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_accepted++;
        predicted = map_access(op, addr, data);
        expected_results.push_back(typed ? typed_result : predicted);
    endtask

    // Stimulus: reset, directed table, random requests, then drain
    initial
    begin
        op_t         op;
        logic [15:0] addr;
        logic [7:0]  data;
        in_valid    <= 1'b0;
        operation   <= OP_IDLE;
        bus_address <= '0;
        write_data  <= '0;
        rst_n       <= 1'b0;
        foreach (nibble_shadow[i])
            nibble_shadow[i] = '0;
        foreach (wram_shadow[i])
            wram_shadow[i] = '0;
        mirror_h   = 1'b0;
        mode_16k   = 1'b0;
        half_sel   = 1'b0;
        prg_bank_q = '0;
        chr_bank_q = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            issue_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                          directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick_random_access(op, addr, data);
            issue_request(op, addr, data, 1'b0, '0);
        end
        in_valid <= 1'b0;

        // wait for every result, then wait out DRAIN_CYCLES to catch stray extras
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d unmapped, %0d data, %0d PRG, %0d CHR, %0d nametable",
                 requests_accepted, results_by_target[TGT_NONE], results_by_target[TGT_DATA],
                 results_by_target[TGT_PRG], results_by_target[TGT_CHR],
                 results_by_target[TGT_NT]);
        $display("Banking writes %0d, work RAM bytes written %0d, mismatches %0d",
                 banking_writes, wram_used.size(), errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("PASS multicart_bank_mapper");
        else
            $display("FAIL multicart_bank_mapper");
        $finish;
    end

    // Result side: random ready pattern with one long hold-off so the pipe
    // fills and the mapper has to drop in_ready
    initial
    begin
        int run;
        int stall;
        bit holdoff_done;
        holdoff_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!holdoff_done && requests_accepted >= HOLDOFF_AT)
            begin
                holdoff_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            run = $urandom_range(1, 40);
            out_ready <= 1'b1;
            repeat (run) @(posedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Compare each accepted result with the oldest pending request
    always @(posedge clk)
    begin
        access_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (target <= TGT_NT)
                results_by_target[target]++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: target %0d address %h data %h",
                       target, mapped_address, read_data);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (target !== want.tgt)
                begin
                    $error("target: expected %0d, got %0d", want.tgt, target);
                    errors++;
                end
                if (mapped_address !== want.maddr)
                begin
                    $error("mapped_address: expected %h, got %h", want.maddr, mapped_address);
                    errors++;
                end
                if (read_data !== want.rdata)
                begin
                    $error("read_data: expected %h, got %h", want.rdata, read_data);
                    errors++;
                end
            end
        end
    end

endmodule
